// File: rtl/core/directional_3x3_edge_filter_unit_assert.svh
// Assertion macros shared by the edge filter RTL.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef DIRECTIONAL_3X3_EDGE_FILTER_UNIT_ASSERT_SVH
`define DIRECTIONAL_3X3_EDGE_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define D3EF_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define D3EF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/d3ef_pkg.sv
package d3ef_pkg;

    // Port field widths.
    localparam int PIX_PORT_W     = 16;
    localparam int KERNEL_MODE_W  = 4;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;

    // Smallest usable frame dimension.
    localparam int MIN_DIM = 3;

    // Clamp limit in 8-bit mode.
    localparam int NARROW_PIXEL_MAX = 255;

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_KERNEL_MODE   = t_cfg_index'(0);
    localparam t_cfg_index CFG_NARROW_PIXELS = t_cfg_index'(1);
    localparam t_cfg_index CFG_FRAME_WIDTH   = t_cfg_index'(2);
    localparam t_cfg_index CFG_FRAME_HEIGHT  = t_cfg_index'(3);

    // Kernel coefficients, taps in raster order (top-left first).
    localparam int KERNEL_COUNT = 12;
    localparam int KERNEL_TAPS  = 9;

    typedef logic signed [2:0] t_coef;

    localparam t_coef N2 = -3'sd2;
    localparam t_coef N1 = -3'sd1;
    localparam t_coef Z0 = 3'sd0;
    localparam t_coef P1 = 3'sd1;
    localparam t_coef P2 = 3'sd2;

    localparam t_coef KERNELS [KERNEL_COUNT][KERNEL_TAPS] = '{
        '{N1, N2, N1, Z0, Z0, Z0, P1, P2, P1},
        '{N1, Z0, P1, N2, Z0, P2, N1, Z0, P1},
        '{Z0, P1, P2, N1, Z0, P1, N2, N1, Z0},
        '{N2, N1, Z0, N1, Z0, P1, Z0, P1, P2},
        '{Z0, Z0, Z0, N1, P1, Z0, Z0, Z0, Z0},
        '{Z0, N1, Z0, Z0, P1, Z0, Z0, Z0, Z0},
        '{Z0, Z0, Z0, Z0, P1, Z0, N1, Z0, Z0},
        '{N1, Z0, Z0, Z0, P1, Z0, Z0, Z0, Z0},
        '{N1, P1, P1, N1, N2, P1, N1, P1, P1},
        '{N1, N1, N1, P1, N2, P1, P1, P1, P1},
        '{P1, P1, P1, N1, N2, P1, N1, N1, P1},
        '{N1, N1, P1, N1, N2, P1, P1, P1, P1}
    };

    typedef struct packed {
        logic [KERNEL_MODE_W-1:0] kernel_mode;
        logic                     narrow;
    } t_filter_ctrl;

    typedef struct packed {
        logic                  last;
        logic [PIX_PORT_W-1:0] pixel;
    } t_result;

endpackage

// File: rtl/core/directional_3x3_edge_filter_unit.sv
// Channel      Direction  Payload (lowest bit first)          Handshake
// -----------  ---------  ----------------------------------  -----------------------
// s_axis       in         tdata: pixel_in[15:0]; tuser: drain  tvalid / tready
// m_axis       out        tdata: pixel_out[15:0]; tlast        tvalid / tready
// cfg          in         index[1:0], data[15:0]               i_cfg_valid / o_cfg_ready
//
// One item is accepted per clock while the queue has room. A result passes the
// stage-1 and stage-2 registers and then waits in a four-entry result queue.
// Synchronous active-low reset clears the counters, the pipeline, the window and the
// queue; the line memory is not cleared and needs no clearing pass.
// s_axis_tready drops only when queued plus in-flight results would exceed the queue
// depth, so a stalled output side throttles the input without losing an item.
// The single-port-read line memory delivers the two stored rows of one column per
// cycle, which sets the one-item-per-clock figure.

`include "directional_3x3_edge_filter_unit_assert.svh"

module directional_3x3_edge_filter_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Pixel stream in. tdata: pixel_in[15:0]. tuser: drain.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [d3ef_pkg::PIX_PORT_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tuser,

    // Filtered stream out. tdata: pixel_out[15:0]. tlast: frame_last.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [d3ef_pkg::PIX_PORT_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,

    // Register writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [d3ef_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [d3ef_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PB     = PIXEL_BITS;
    localparam int CW     = $clog2(MAX_WIDTH);      // column index
    localparam int WW     = $clog2(MAX_WIDTH + 1);  // holds the width itself
    localparam int PW     = $clog2(MAX_WIDTH + 2);  // holds width plus one
    localparam int HW     = d3ef_pkg::FRAME_HEIGHT_W;
    localparam int CNT_W  = d3ef_pkg::FIFO_AW + 1;
    localparam int PORT_W = d3ef_pkg::PIX_PORT_W;

    // Item that has issued its line-memory read and waits for the data.
    typedef struct packed {
        logic          is_drain;
        logic [PB-1:0] pix;
        logic [CW-1:0] addr;
        logic          has_res;
        logic          pass;
        logic          drain_older;
        logic          drain_last;
    } t_stage1;

    // Item whose window is loaded and whose result is chosen as it enters the queue.
    typedef struct packed {
        logic          pass;
        logic [PB-1:0] value;
        logic          last;
    } t_stage2;

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls.
    // ------------------------------------------------------------------
    logic [d3ef_pkg::KERNEL_MODE_W-1:0]  r_kernel_mode;
    logic                                r_narrow;
    logic [d3ef_pkg::FRAME_WIDTH_W-1:0]  r_frame_width;
    logic [HW-1:0]                       r_frame_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mode  <= '0;
            r_narrow       <= 1'b0;
            r_frame_width  <= d3ef_pkg::FRAME_WIDTH_W'(1024);
            r_frame_height <= HW'(1024);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                d3ef_pkg::CFG_KERNEL_MODE:
                    r_kernel_mode <= i_cfg_data[d3ef_pkg::KERNEL_MODE_W-1:0];
                d3ef_pkg::CFG_NARROW_PIXELS:
                    r_narrow <= i_cfg_data[0];
                d3ef_pkg::CFG_FRAME_WIDTH:
                    r_frame_width <= i_cfg_data[d3ef_pkg::FRAME_WIDTH_W-1:0];
                d3ef_pkg::CFG_FRAME_HEIGHT:
                    r_frame_height <= i_cfg_data[HW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective frame size: width is clamped to 3..MAX_WIDTH, height to 3 and up.
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    always_comb begin
        priority if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else if (r_frame_width < d3ef_pkg::FRAME_WIDTH_W'(d3ef_pkg::MIN_DIM)) begin
            eff_w = WW'(d3ef_pkg::MIN_DIM);
        end else begin
            eff_w = WW'(r_frame_width);
        end
        if (r_frame_height < HW'(d3ef_pkg::MIN_DIM)) begin
            eff_h = HW'(d3ef_pkg::MIN_DIM);
        end else begin
            eff_h = r_frame_height;
        end
    end

    // ------------------------------------------------------------------
    // Position tracking at the input. Each pixel accepted past the first of
    // the second row gives the result for the pixel one line plus one pixel
    // earlier; after the last pixel, the owed tail is pulled out by drains.
    // ------------------------------------------------------------------
    logic [CW-1:0] r_in_col, n_in_col;
    logic [HW-1:0] r_in_row, n_in_row;
    logic [PW-1:0] r_pending, n_pending;

    logic          s_acc;
    logic [WW-1:0] cur_col;
    logic [HW-1:0] cur_row;
    logic          last_col;
    logic          last_row;
    logic          has_res;
    logic          pass;
    logic [PB-1:0] pix_masked;
    logic [PW-1:0] w_plus1;
    logic          drain_active;
    logic          drain_first;
    logic          drain_last;
    logic [WW-1:0] drain_addr;
    logic [PW-1:0] pend_after_drain;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        cur_col = (WW'(r_in_col) >= eff_w) ? eff_w - WW'(1) : WW'(r_in_col);
        cur_row = (r_in_row >= eff_h) ? eff_h - HW'(1) : r_in_row;

        last_col = (cur_col == eff_w - WW'(1));
        last_row = (cur_row == eff_h - HW'(1));

        // A result is due once the input has moved past the first pixel of the
        // second row. The first and last columns and the first row of the frame
        // are passed through unchanged, as is the last row given out by drains.
        has_res = (cur_row >= HW'(2)) || ((cur_row == HW'(1)) && (cur_col != '0));
        pass    = (cur_col <= WW'(1)) || (cur_row == HW'(1));

        if (r_narrow) begin
            pix_masked = PB'(s_axis_tdata[7:0]);
        end else begin
            pix_masked = s_axis_tdata[PB-1:0];
        end

        // Tail: the first drain gives the last pixel of the next-to-last row,
        // the rest give the last row from left to right.
        w_plus1          = PW'(eff_w) + PW'(1);
        drain_active     = (r_pending != '0);
        drain_first      = (r_pending >= w_plus1);
        drain_last       = (r_pending == PW'(1));
        drain_addr       = drain_first ? eff_w - WW'(1) : eff_w - WW'(r_pending);
        pend_after_drain = drain_first ? PW'(eff_w) : r_pending - PW'(1);
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_pending = r_pending;
        if (s_acc) begin
            if (s_axis_tuser) begin
                if (drain_active) begin
                    n_pending = pend_after_drain;
                end
            end else begin
                n_pending = '0;
                if (last_col) begin
                    n_in_col = '0;
                    if (last_row) begin
                        n_in_row  = '0;
                        n_pending = w_plus1;
                    end else begin
                        n_in_row = cur_row + HW'(1);
                    end
                end else begin
                    n_in_col = CW'(cur_col + WW'(1));
                    n_in_row = cur_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_pending <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_pending <= n_pending;
        end
    end

    // ------------------------------------------------------------------
    // Line memory. Entry c holds the two most recent rows of column c, the
    // older one in the upper half. A pixel reads its column and writes it
    // back shifted by one row; a drain reads one stored pixel of the tail.
    // ------------------------------------------------------------------
    logic            ram_we;
    logic            ram_re;
    logic [CW-1:0]   ram_raddr;
    logic [2*PB-1:0] ram_wdata;
    logic [2*PB-1:0] ram_rdata;
    logic [2*PB-1:0] rd_pair;
    logic [PB-1:0]   rd_older;
    logic [PB-1:0]   rd_newer;
    logic            r_byp;
    logic [2*PB-1:0] r_byp_data;
    logic            n_byp;

    t_stage1 r_s1;
    logic    r_s1_valid;

    assign ram_re    = s_acc && (!s_axis_tuser || drain_active);
    assign ram_raddr = s_axis_tuser ? drain_addr[CW-1:0] : cur_col[CW-1:0];

    // The memory returns old data when a read meets a write at the same
    // column, which happens when the first drain follows the last pixel.
    assign rd_pair   = r_byp ? r_byp_data : ram_rdata;
    assign rd_older  = rd_pair[2*PB-1:PB];
    assign rd_newer  = rd_pair[PB-1:0];

    assign ram_we    = r_s1_valid && !r_s1.is_drain;
    assign ram_wdata = {rd_newer, r_s1.pix};
    assign n_byp     = ram_we && ram_re && (r_s1.addr == ram_raddr);

    d3ef_ram #(
        .WIDTH (2 * PB),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_byp      <= n_byp;
            r_s1_valid <= ram_re;
        end
        r_byp_data <= ram_wdata;
        if (s_acc) begin
            r_s1.is_drain    <= s_axis_tuser;
            r_s1.pix         <= pix_masked;
            r_s1.addr        <= cur_col[CW-1:0];
            r_s1.has_res     <= has_res;
            r_s1.pass        <= pass;
            r_s1.drain_older <= drain_first;
            r_s1.drain_last  <= drain_last;
        end
    end

    // ------------------------------------------------------------------
    // 3x3 window. Columns shift left by one per pixel; the new right column
    // is the two stored rows plus the incoming pixel. The mid-right tap before
    // the shift is the original pixel of the result being produced.
    // ------------------------------------------------------------------
    logic [PB-1:0] r_win [9];
    t_stage2       r_s2, n_s2;
    logic          r_s2_valid, n_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (ram_we) begin
            for (int i = 0; i < 3; i++) begin
                r_win[3*i]   <= r_win[3*i+1];
                r_win[3*i+1] <= r_win[3*i+2];
            end
            r_win[2] <= rd_older;
            r_win[5] <= rd_newer;
            r_win[8] <= r_s1.pix;
        end
    end

    always_comb begin
        n_s2_valid = r_s1_valid && (r_s1.is_drain || r_s1.has_res);
        if (r_s1.is_drain) begin
            n_s2.pass  = 1'b1;
            n_s2.value = r_s1.drain_older ? rd_older : rd_newer;
            n_s2.last  = r_s1.drain_last;
        end else begin
            n_s2.pass  = r_s1.pass;
            n_s2.value = r_win[5];
            n_s2.last  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= n_s2_valid;
        end
        r_s2 <= n_s2;
    end

    // ------------------------------------------------------------------
    // Kernel sum and clamp, then the result queue.
    // ------------------------------------------------------------------
    d3ef_pkg::t_filter_ctrl filt_ctrl;
    logic [PB-1:0]          filt_pixel;

    assign filt_ctrl.kernel_mode = r_kernel_mode;
    assign filt_ctrl.narrow      = r_narrow;

    d3ef_filter #(
        .PIXEL_BITS (PB)
    ) u_filter (
        .i_window (r_win),
        .i_ctrl   (filt_ctrl),
        .o_pixel  (filt_pixel)
    );

    d3ef_pkg::t_result               r_fifo [d3ef_pkg::FIFO_DEPTH];
    d3ef_pkg::t_result               push_data;
    d3ef_pkg::t_result               head;
    logic [d3ef_pkg::FIFO_AW-1:0]    r_wr_ptr;
    logic [d3ef_pkg::FIFO_AW-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]                r_fifo_count;
    logic [CNT_W-1:0]                inflight;
    logic                            push;
    logic                            pop;

    assign push            = r_s2_valid;
    assign push_data.last  = r_s2.last;
    assign push_data.pixel = PORT_W'(r_s2.pass ? r_s2.value : filt_pixel);

    assign head          = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_fifo_count != '0);
    assign m_axis_tdata  = head.pixel;
    assign m_axis_tlast  = head.last;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // Every item in the two pipeline stages holds a queue slot in advance.
    assign inflight      = r_fifo_count + CNT_W'(r_s1_valid) + CNT_W'(r_s2_valid);
    assign s_axis_tready = (inflight < CNT_W'(d3ef_pkg::FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fifo_count <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + d3ef_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + d3ef_pkg::FIFO_AW'(1);
            end
            r_fifo_count <= r_fifo_count + CNT_W'(push) - CNT_W'(pop);
        end
        if (push) begin
            r_fifo[r_wr_ptr] <= push_data;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `D3EF_ASSERT_IMPLY(a_queue_credit, 1'b1, inflight <= CNT_W'(d3ef_pkg::FIFO_DEPTH), "result queue overcommitted")
    `D3EF_ASSERT_NEXT(a_drain_gives_result, r_s1_valid && r_s1.is_drain, r_s2_valid && r_s2.pass, "drain item lost its result")
    `D3EF_ASSERT_IMPLY(a_last_only_on_tail, r_s2_valid && r_s2.last, r_s2.pass && $past(r_s1.is_drain), "frame end marked outside the tail")

endmodule

// File: rtl/core/d3ef_ram.sv
module d3ef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/d3ef_filter.sv
module d3ef_filter #(
    parameter int PIXEL_BITS = 16
) (
    input  logic [PIXEL_BITS-1:0]  i_window [9],
    input  d3ef_pkg::t_filter_ctrl i_ctrl,
    output logic [PIXEL_BITS-1:0]  o_pixel
);

    // Nine taps of weight up to two, plus the offset, stay well inside this.
    localparam int SW = PIXEL_BITS + 6;

    localparam logic signed [SW-1:0] WIDE_OFFSET = SW'(2 ** (PIXEL_BITS - 1));
    localparam logic signed [SW-1:0] WIDE_MAX    = SW'(2 ** PIXEL_BITS - 1);
    localparam logic signed [SW-1:0] NARROW_MAX  = SW'(d3ef_pkg::NARROW_PIXEL_MAX);

    d3ef_pkg::t_coef         coef [9];
    logic signed [SW-1:0]    pix_ext [9];
    logic signed [SW-1:0]    term [9];
    logic signed [SW-1:0]    row_sum [3];
    logic signed [SW-1:0]    total;
    logic signed [SW-1:0]    hi;
    logic signed [SW-1:0]    clamped;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (32'(i_ctrl.kernel_mode) < 32'(d3ef_pkg::KERNEL_COUNT)) begin
                coef[k] = d3ef_pkg::KERNELS[i_ctrl.kernel_mode][k];
            end else begin
                coef[k] = d3ef_pkg::Z0;
            end
            pix_ext[k] = SW'(i_window[k]);
            unique case (coef[k])
                d3ef_pkg::P1: term[k] = pix_ext[k];
                d3ef_pkg::N1: term[k] = -pix_ext[k];
                d3ef_pkg::P2: term[k] = pix_ext[k] <<< 1;
                d3ef_pkg::N2: term[k] = -(pix_ext[k] <<< 1);
                default:      term[k] = '0;
            endcase
        end

        for (int i = 0; i < 3; i++) begin
            row_sum[i] = term[3*i] + term[3*i+1] + term[3*i+2];
        end

        total = row_sum[0] + row_sum[1] + row_sum[2];
        if (i_ctrl.narrow) begin
            hi = NARROW_MAX;
        end else begin
            total = total + WIDE_OFFSET;
            hi    = WIDE_MAX;
        end

        priority if (total < 0) begin
            clamped = '0;
        end else if (total > hi) begin
            clamped = hi;
        end else begin
            clamped = total;
        end
    end

    assign o_pixel = clamped[PIXEL_BITS-1:0];

endmodule

// File: sim/tb_top.sv
module tb_top;
    import d3ef_pkg::*;

    localparam int LINE_LEN     = 1024;   // line memory row length of the default build
    localparam int SETTLE       = 16;     // pipeline plus result queue, with margin
    localparam int STALL_LIMIT  = 2000;   // cycles without any handshake
    localparam int RANDOM_ITEMS = 1100;

    // Coefficients in raster order, top-left first: gradient S, E, NE, SE;
    // shift difference E, S, NE, SE; Prewitt-style E, S, NE, SE.
    localparam int TAPS [12][9] = '{
        '{-1, -2, -1,  0,  0,  0,  1,  2,  1},
        '{-1,  0,  1, -2,  0,  2, -1,  0,  1},
        '{ 0,  1,  2, -1,  0,  1, -2, -1,  0},
        '{-2, -1,  0, -1,  0,  1,  0,  1,  2},
        '{ 0,  0,  0, -1,  1,  0,  0,  0,  0},
        '{ 0, -1,  0,  0,  1,  0,  0,  0,  0},
        '{ 0,  0,  0,  0,  1,  0, -1,  0,  0},
        '{-1,  0,  0,  0,  1,  0,  0,  0,  0},
        '{-1,  1,  1, -1, -2,  1, -1,  1,  1},
        '{-1, -1, -1,  1, -2,  1,  1,  1,  1},
        '{ 1,  1,  1, -1, -2,  1, -1, -1,  1},
        '{-1, -1,  1, -1, -2,  1,  1,  1,  1}
    };

    typedef struct {
        logic [15:0] data;
        logic        drain;
    } feed_t;

    typedef struct {
        logic [15:0] pixel;
        logic        last;
    } owed_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [PIX_PORT_W-1:0]   s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [PIX_PORT_W-1:0]   m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    t_cfg_index              i_cfg_index = CFG_KERNEL_MODE;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    // Register copies as last written.
    logic [3:0]  cfg_kernel = 4'd0;
    logic        cfg_narrow = 1'b0;
    logic [15:0] cfg_width  = 16'd1024;
    logic [15:0] cfg_height = 16'd1024;

    // Filter state mirrored from the block.
    logic [15:0] line_copy [2*LINE_LEN] = '{default: '0};
    logic [15:0] win [9] = '{default: '0};
    int unsigned in_col = 0;
    int unsigned in_row = 0;
    int unsigned tail_owed = 0;

    feed_t pixel_feed [$];
    owed_t owed_pixels [$];
    int    n_queued = 0;
    int    n_accepted = 0;
    int    fed = 0;
    int    snd_idle = 0;
    int    rcv_idle = 0;
    int    quiet_cycles = 0;
    bit    failed = 1'b0;

    directional_3x3_edge_filter_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Sizes outside the legal range are clamped, not rejected.
    function automatic int unsigned eff_width(input logic [15:0] v);
        logic [10:0] x = v[10:0];
        if (x < MIN_DIM) return MIN_DIM;
        if (x > LINE_LEN) return LINE_LEN;
        return x;
    endfunction

    function automatic int unsigned eff_height(input logic [15:0] v);
        return (v < MIN_DIM) ? MIN_DIM : v;
    endfunction

    // Advances the mirrored state by one accepted item and records the
    // result it owes, if any.
    function automatic void filter_item(input logic [15:0] data, input logic drain);
        int unsigned w, h, r, c, d, pr, pc, cur, prv;
        logic [15:0] pix, top, mid, orig;
        int sum, hi;
        owed_t res;
        w = eff_width(cfg_width);
        h = eff_height(cfg_height);
        if (drain) begin
            // A drain only matters while a frame tail is still owed.
            if (tail_owed != 0) begin
                d = (tail_owed > w + 1) ? 0 : w + 1 - tail_owed;
                if (d == 0)
                    orig = line_copy[((h - 2) & 1) * LINE_LEN + w - 1];
                else
                    orig = line_copy[((h - 1) & 1) * LINE_LEN + d - 1];
                tail_owed = (tail_owed > w + 1) ? w : tail_owed - 1;
                res.pixel = orig;
                res.last  = (d == w);
                owed_pixels.push_back(res);
            end
        end else begin
            // Any pixel drops an unflushed tail and belongs to the next frame.
            tail_owed = 0;
            pix = cfg_narrow ? {8'h00, data[7:0]} : data;
            c = (in_col >= w) ? w - 1 : in_col;
            r = (in_row >= h) ? h - 1 : in_row;
            cur = (r & 1) * LINE_LEN;
            prv = ((r + 1) & 1) * LINE_LEN;
            top = line_copy[cur + c];
            mid = line_copy[prv + c];
            orig = (c >= 1) ? line_copy[prv + c - 1] : line_copy[cur + w - 1];
            for (int i = 0; i < 3; i++) begin
                win[3*i]   = win[3*i + 1];
                win[3*i+1] = win[3*i + 2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = pix;
            line_copy[cur + c] = pix;

            // The result trails the input by one row plus one pixel.
            if (r >= 2 || (r == 1 && c >= 1)) begin
                if (c >= 1) begin
                    pr = r - 1;
                    pc = c - 1;
                end else begin
                    pr = r - 2;
                    pc = w - 1;
                end
                if (pr == 0 || pc == 0 || pc == w - 1) begin
                    res.pixel = orig;
                end else begin
                    sum = 0;
                    if (cfg_kernel < 12)
                        for (int k = 0; k < 9; k++)
                            sum += TAPS[cfg_kernel][k] * int'(win[k]);
                    if (cfg_narrow) begin
                        hi = NARROW_PIXEL_MAX;
                    end else begin
                        sum += 32768;
                        hi = 65535;
                    end
                    if (sum < 0) sum = 0;
                    if (sum > hi) sum = hi;
                    res.pixel = sum[15:0];
                end
                res.last = 1'b0;
                owed_pixels.push_back(res);
            end

            if (c + 1 >= w) begin
                in_col = 0;
                if (r + 1 >= h) begin
                    in_row = 0;
                    tail_owed = w + 1;
                end else begin
                    in_row = r + 1;
                end
            end else begin
                in_col = c + 1;
                in_row = r;
            end
        end
    endfunction

    // Track register writes and feed every accepted item to the mirror.
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KERNEL_MODE:   cfg_kernel = i_cfg_data[3:0];
                CFG_NARROW_PIXELS: cfg_narrow = i_cfg_data[0];
                CFG_FRAME_WIDTH:   cfg_width  = {5'd0, i_cfg_data[10:0]};
                CFG_FRAME_HEIGHT:  cfg_height = i_cfg_data;
                default: ;
            endcase
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            filter_item(s_axis_tdata, s_axis_tuser);
            n_accepted++;
        end
    end

    // Sender: holds an item until it is taken, then may idle before the next one.
    always @(posedge i_clk) begin
        feed_t item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pixel_feed.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
                item = pixel_feed.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= item.data;
                s_axis_tuser  <= item.drain;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, and each taken item checked in order.
    always @(posedge i_clk) begin
        owed_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (owed_pixels.size() == 0) begin
                $display("%0t: unexpected item, expected none, got pixel %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                failed = 1'b1;
            end else begin
                want = owed_pixels.pop_front();
                if (m_axis_tdata !== want.pixel) begin
                    $display("%0t: pixel_out expected %h, got %h",
                             $time, want.pixel, m_axis_tdata);
                    failed = 1'b1;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: frame_last expected %b, got %b",
                             $time, want.last, m_axis_tlast);
                    failed = 1'b1;
                end
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= rcv_idle);
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("directional_3x3_edge_filter_unit: mismatch");
            $finish;
        end
    end

    task automatic queue_item(input logic [15:0] data, input logic drain);
        feed_t item;
        item.data  = data;
        item.drain = drain;
        pixel_feed.push_back(item);
        n_queued++;
    endtask

    // One frame of raster pixels, with stray drains mixed in, followed by a given number of drains.
    task automatic queue_frame(input int unsigned w, input int unsigned h,
                               input int unsigned tail);
        logic [15:0] v;
        for (int i = 0; i < w * h; i++) begin
            // Stray drains find nothing pending, save one ahead of the first pixel.
            if ($urandom_range(0, 99) < 3)
                queue_item(16'($urandom), 1'b1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: v = 16'($urandom);
                5, 6: begin
                    case ($urandom_range(0, 3))
                        0: v = 16'h0000;
                        1: v = 16'hFFFF;
                        2: v = 16'h00FF;
                        default: v = 16'h8000;
                    endcase
                end
                default: v = {8'h00, 8'($urandom)};
            endcase
            queue_item(v, 1'b0);
        end
        for (int i = 0; i < tail; i++)
            queue_item(16'($urandom), 1'b1);
        fed += w * h + ((tail > w + 1) ? w + 1 : tail);
    endtask

    // Writes all four registers back to back; valid stays high throughout.
    task automatic set_config(input logic [15:0] km, input logic [15:0] nar,
                              input logic [15:0] wv, input logic [15:0] hv);
        logic [15:0] vals [4];
        t_cfg_index  idx [4];
        vals = '{km, nar, wv, hv};
        idx  = '{CFG_KERNEL_MODE, CFG_NARROW_PIXELS, CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Waits for all items to be taken and all owed results to arrive, then
    // lets items that produce nothing clear the pipeline.
    task automatic wait_drained();
        while (n_accepted != n_queued || owed_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] rising [9];
        logic [15:0] falling [9];
        logic [15:0] wv, hv;
        int unsigned w, h, nframes, tail;
        int phase;
        rising  = '{16'h0000, 16'h0000, 16'h0000,
                    16'h1234, 16'hFFFF, 16'h4321,
                    16'hFFFF, 16'hFFFF, 16'hFFFF};
        falling = '{16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'h8000, 16'h0000, 16'h7FFF,
                    16'h0000, 16'h0000, 16'h0000};
        phase = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle = 36;
        rcv_idle = 50;

        // Smallest frame: a drain with nothing owed, a frame whose centre
        // clamps high, a tail cut short by the next frame whose centre
        // clamps low, then a full tail ending on frame_last.
        set_config(16'd0, 16'd0, 16'd3, 16'd3);
        queue_item(16'hA5A5, 1'b1);
        foreach (rising[i]) queue_item(rising[i], 1'b0);
        repeat (2) queue_item(16'h5A5A, 1'b1);
        foreach (falling[i]) queue_item(falling[i], 1'b0);
        repeat (4) queue_item(16'hFFFF, 1'b1);
        wait_drained();

        // Widest line: width register beyond the limit, narrow pixels.
        set_config(16'd9, 16'hFFFF, 16'hFFFF, 16'd3);
        queue_frame(LINE_LEN, 3, LINE_LEN + 1);
        wait_drained();

        // Random phases, each a fresh setting with one to three small frames.
        fed = 0;
        while (fed < RANDOM_ITEMS || phase < 16) begin
            if (fed < RANDOM_ITEMS / 3) begin
                snd_idle = 36;
                rcv_idle = 50;
            end else if (fed < 2 * RANDOM_ITEMS / 3) begin
                snd_idle = 50;
                rcv_idle = 36;
            end else begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            case (phase % 5)
                1: wv = 16'($urandom_range(0, 2));
                3: wv = 16'hF800 | 16'($urandom_range(3, 8));
                default: wv = 16'($urandom_range(3, 9));
            endcase
            hv = (phase % 4 == 2) ? 16'($urandom_range(0, 2)) : 16'($urandom_range(3, 6));
            set_config((phase < 16) ? 16'(phase) : 16'($urandom_range(0, 15)),
                       16'($urandom_range(0, 1)), wv, hv);
            w = eff_width(wv);
            h = eff_height(hv);
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                // Only the last frame of a phase must be fully flushed.
                if (f == nframes - 1 || $urandom_range(0, 1) == 0)
                    tail = w + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
                else
                    tail = $urandom_range(0, w);
                queue_frame(w, h, tail);
            end
            wait_drained();
            phase++;
        end

        // Full-size line with the tallest frame; the run stops mid-frame.
        snd_idle = 0;
        rcv_idle = 0;
        set_config(16'($urandom_range(0, 15)), 16'd0, 16'd1024, 16'hFFFF);
        queue_frame(LINE_LEN, 3, 0);
        wait_drained();

        if (!failed)
            $display("directional_3x3_edge_filter_unit: match");
        else
            $display("directional_3x3_edge_filter_unit: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/d3ef_pkg.sv
rtl/core/d3ef_ram.sv
rtl/core/d3ef_filter.sv
rtl/core/directional_3x3_edge_filter_unit.sv
sim/tb_top.sv
